/* hdl/gprt_pkg.sv */
package gprt_pkg;

  // Tick operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REFILL = 2'd1,
    OP_RESET  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Rotation controller, one-hot
  typedef enum logic [4:0] {
    PS_STANDBY = 5'b00001,
    PS_A_START = 5'b00010,
    PS_A_RUN   = 5'b00100,
    PS_B_START = 5'b01000,
    PS_B_RUN   = 5'b10000
  } pair_st_e;

  // Reported pair state codes
  localparam logic [2:0] PAIR_CODE_STANDBY = 3'd0;
  localparam logic [2:0] PAIR_CODE_A_START = 3'd1;
  localparam logic [2:0] PAIR_CODE_A_RUN   = 3'd2;
  localparam logic [2:0] PAIR_CODE_B_START = 3'd3;
  localparam logic [2:0] PAIR_CODE_B_RUN   = 3'd4;

  // Overall generator status
  typedef enum logic [1:0] {
    GS_STANDBY  = 2'd0,
    GS_STARTING = 2'd1,
    GS_RUNNING  = 2'd2
  } gen_st_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 27;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP   = 2'd1;

  localparam logic [26:0] SHIFT_LEN_RST = 27'd480000;
  localparam logic [15:0] STARTUP_RST   = 16'd3500;

  // Plant limits
  localparam logic [29:0] FUEL_FULL   = 30'd1000000000;
  localparam logic [36:0] CHARGE_FULL = 37'd100000000000;
  localparam logic [35:0] TEMP_HOME   = 36'd21000000000;
  localparam logic [35:0] TEMP_MAX    = 36'd45000000000;

  // Per-ms rates and base loads in watts
  localparam logic [21:0] FUEL_RUN_RATE   = 22'd39;
  localparam logic [21:0] FUEL_START_RATE = 22'd45;
  localparam logic [31:0] CHARGE_RATE     = 32'd50000;
  localparam logic [32:0] COOL_RATE       = 33'd80000;
  localparam logic [20:0] BATT_BASE_W     = 21'd40000;
  localparam logic [20:0] HEAT_BASE_W     = 21'd50000;

endpackage

/* hdl/generator_pair_rotation_tick_core.sv */
// Generator pair rotation controller, one tick per input beat.
// Input channel (in_valid_i/in_ready_o) carries an op, the tick length in ms,
// the site flags and the summed UPS and server loads. Each accepted beat
// produces exactly one output beat (out_valid_o/out_ready_i) holding the
// controller state after that tick: pair and generator status, fuel, battery
// charge, room temperature and per-unit run time.
// Each beat lands in the input register (where the two load products are formed)
// and then updates the state registers, which are also the output register.
// Throughput is one beat per cycle while out_ready_i takes the results, with a
// single state update per accepted beat.
// The input register keeps accepting while a result waits, so one beat can
// queue behind a stalled result; with both full, in_ready_o drops until
// out_ready_i takes the pending result.
// Reset (rst_ni low) returns to standby, full fuel and charge, home
// temperature, zero run times and the default shift and startup times.
// Configuration writes (cfg_we_i) take effect at once; write only while idle.
module generator_pair_rotation_tick_core #(
  parameter int unsigned RUN_TIME_BITS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [gprt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gprt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // tick input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [15:0]                      dt_ms_i,
  input  logic                             grid_ok_i,
  input  logic                             fire_alarm_i,
  input  logic                             cooling_enabled_i,
  input  logic                             auto_start_i,
  input  logic [19:0]                      ups_load_w_i,
  input  logic [19:0]                      server_load_w_i,
  // result
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       pair_state_o,
  output logic [1:0]                       gen_state_o,
  output logic                             active_pair_o,
  output logic [29:0]                      fuel_ul_o,
  output logic [36:0]                      battery_charge_o,
  output logic [35:0]                      room_temp_o,
  output logic [RUN_TIME_BITS-1:0]         run_time_gen1_o,
  output logic [RUN_TIME_BITS-1:0]         run_time_gen2_o,
  output logic [RUN_TIME_BITS-1:0]         run_time_gen3_o,
  output logic [RUN_TIME_BITS-1:0]         run_time_gen4_o
);
  import gprt_pkg::*;

  localparam logic [RUN_TIME_BITS-1:0] RUN_MAX = {RUN_TIME_BITS{1'b1}};

  // configuration registers
  logic [26:0] shift_len_q;
  logic [15:0] startup_q;

  // input register
  logic        s1_valid_q;
  op_e         s1_op_q;
  logic [15:0] s1_dt_q;
  logic        s1_grid_q, s1_fire_q, s1_cool_q, s1_auto_q;
  logic [35:0] s1_dis_q;
  logic [36:0] s1_heat_q;

  // controller state, also the result register
  logic        out_valid_q;
  pair_st_e    st_q, st_d;
  gen_st_e     gs_q, gs_d;
  logic        pair_q, pair_d;
  logic [16:0] spool_q, spool_d;
  logic [26:0] shift_q, shift_d;
  logic [29:0] fuel_q, fuel_d;
  logic [36:0] chg_q, chg_d;
  logic [35:0] temp_q, temp_d;
  logic [RUN_TIME_BITS-1:0] rt_q [4];
  logic [RUN_TIME_BITS-1:0] rt_d [4];

  logic s1_adv;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_len_q <= SHIFT_LEN_RST;
      startup_q   <= STARTUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHIFT_LEN: shift_len_q <= cfg_data_i;
        CFG_STARTUP:   startup_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // load products formed on the way into the input register
  logic [20:0] ups_sum, srv_sum;
  logic [36:0] dis_prod, heat_prod;

  assign ups_sum   = {1'b0, ups_load_w_i} + BATT_BASE_W;
  assign srv_sum   = {1'b0, server_load_w_i} + HEAT_BASE_W;
  assign dis_prod  = {21'd0, dt_ms_i} * {16'd0, ups_sum};
  assign heat_prod = {21'd0, dt_ms_i} * {16'd0, srv_sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= op_e'(op_i);
      s1_dt_q   <= dt_ms_i;
      s1_grid_q <= grid_ok_i;
      s1_fire_q <= fire_alarm_i;
      s1_cool_q <= cooling_enabled_i;
      s1_auto_q <= auto_start_i;
      s1_dis_q  <= dis_prod[36:1];
      s1_heat_q <= heat_prod;
    end
  end

  // timer, run time and fuel arithmetic
  logic [16:0] spool_sum;
  logic        spool_done;
  logic [27:0] shift_sum;
  logic [26:0] shift_sat;
  logic        shift_due;
  logic [21:0] drain_run, drain_start;
  logic [29:0] fuel_run, fuel_start;
  logic [RUN_TIME_BITS-1:0] rt_sat [4];

  assign spool_sum   = spool_q + {1'b0, s1_dt_q};
  assign spool_done  = spool_sum >= {1'b0, startup_q};
  assign shift_sum   = {1'b0, shift_q} + {12'd0, s1_dt_q};
  assign shift_sat   = shift_sum[27] ? 27'h7FFFFFF : shift_sum[26:0];
  assign shift_due   = shift_sat >= shift_len_q;
  assign drain_run   = {6'd0, s1_dt_q} * FUEL_RUN_RATE;
  assign drain_start = {6'd0, s1_dt_q} * FUEL_START_RATE;
  assign fuel_run    = ({8'd0, drain_run} >= fuel_q) ? 30'd0
                                                     : fuel_q - {8'd0, drain_run};
  assign fuel_start  = ({8'd0, drain_start} >= fuel_q) ? 30'd0
                                                       : fuel_q - {8'd0, drain_start};

  always_comb begin
    logic [RUN_TIME_BITS:0] sum;
    for (int i = 0; i < 4; i++) begin
      sum       = {1'b0, rt_q[i]} + (RUN_TIME_BITS+1)'(s1_dt_q);
      rt_sat[i] = sum[RUN_TIME_BITS] ? RUN_MAX : sum[RUN_TIME_BITS-1:0];
    end
  end

  // battery and temperature arithmetic
  logic [31:0] chg_inc;
  logic [37:0] chg_up;
  logic [36:0] chg_fall, chg_rise;
  logic [37:0] temp_up;
  logic [35:0] temp_heat;
  logic [32:0] cool_amt;
  logic [35:0] temp_ex, temp_cool;

  assign chg_inc   = {16'd0, s1_dt_q} * CHARGE_RATE;
  assign chg_up    = {1'b0, chg_q} + {6'd0, chg_inc};
  assign chg_rise  = (chg_up > {1'b0, CHARGE_FULL}) ? CHARGE_FULL : chg_up[36:0];
  assign chg_fall  = ({1'b0, s1_dis_q} >= chg_q) ? 37'd0 : chg_q - {1'b0, s1_dis_q};
  assign temp_up   = {2'd0, temp_q} + {1'b0, s1_heat_q};
  assign temp_heat = (temp_up > {2'd0, TEMP_MAX}) ? TEMP_MAX : temp_up[35:0];
  assign cool_amt  = {17'd0, s1_dt_q} * COOL_RATE;
  assign temp_ex   = temp_q - TEMP_HOME;
  assign temp_cool = (temp_ex <= {3'd0, cool_amt}) ? TEMP_HOME
                                                    : temp_q - {3'd0, cool_amt};

  // next state for one tick
  always_comb begin
    logic charger_on;
    logic cool_on;
    st_d    = st_q;
    gs_d    = gs_q;
    pair_d  = pair_q;
    spool_d = spool_q;
    shift_d = shift_q;
    fuel_d  = fuel_q;
    chg_d   = chg_q;
    temp_d  = temp_q;
    for (int i = 0; i < 4; i++) rt_d[i] = rt_q[i];
    charger_on = 1'b0;
    cool_on    = 1'b0;

    case (s1_op_q)
      OP_TICK: begin
        // rotation controller
        if (!s1_grid_q && s1_auto_q && (fuel_q != 30'd0) && !s1_fire_q) begin
          case (st_q)
            PS_STANDBY: begin
              st_d    = PS_A_START;
              pair_d  = 1'b0;
              gs_d    = GS_STARTING;
              spool_d = '0;
              shift_d = '0;
            end
            PS_A_START: begin
              spool_d = spool_sum;
              if (spool_done) begin
                st_d    = PS_A_RUN;
                gs_d    = GS_RUNNING;
                spool_d = '0;
              end
            end
            PS_A_RUN: begin
              shift_d = shift_sat;
              rt_d[0] = rt_sat[0];
              rt_d[2] = rt_sat[2];
              fuel_d  = fuel_run;
              if (shift_due && (fuel_run != 30'd0)) begin
                st_d    = PS_B_START;
                pair_d  = 1'b1;
                spool_d = '0;
              end
            end
            PS_B_START: begin
              // pair A keeps running while B spools up
              spool_d = spool_sum;
              rt_d[0] = rt_sat[0];
              rt_d[2] = rt_sat[2];
              fuel_d  = fuel_start;
              if (spool_done) begin
                st_d    = PS_B_RUN;
                gs_d    = GS_RUNNING;
                spool_d = '0;
                shift_d = '0;
              end
            end
            default: begin
              shift_d = shift_sat;
              rt_d[1] = rt_sat[1];
              rt_d[3] = rt_sat[3];
              fuel_d  = fuel_run;
              if (shift_due && (fuel_run != 30'd0)) begin
                st_d    = PS_A_START;
                pair_d  = 1'b0;
                spool_d = '0;
                gs_d    = GS_STARTING;
              end
            end
          endcase
          // out of fuel
          if (fuel_d == 30'd0) begin
            st_d    = PS_STANDBY;
            gs_d    = GS_STANDBY;
            spool_d = '0;
            shift_d = '0;
          end
        end else if (s1_grid_q || s1_fire_q) begin
          if (st_q != PS_STANDBY) begin
            st_d    = PS_STANDBY;
            gs_d    = GS_STANDBY;
            spool_d = '0;
            shift_d = '0;
          end
        end

        // battery, using the status after this tick
        charger_on = s1_grid_q || (gs_d == GS_RUNNING);
        if (!charger_on) begin
          chg_d = chg_fall;
        end else if (chg_q < CHARGE_FULL) begin
          chg_d = chg_rise;
        end

        // room temperature
        cool_on = s1_cool_q && charger_on && !s1_fire_q;
        if (!cool_on) begin
          temp_d = temp_heat;
        end else if (temp_q > TEMP_HOME) begin
          temp_d = temp_cool;
        end
      end
      OP_REFILL: begin
        fuel_d = FUEL_FULL;
        chg_d  = CHARGE_FULL;
        temp_d = TEMP_HOME;
      end
      OP_RESET: begin
        st_d    = PS_STANDBY;
        gs_d    = GS_STANDBY;
        pair_d  = 1'b0;
        spool_d = '0;
        shift_d = '0;
        fuel_d  = FUEL_FULL;
        chg_d   = CHARGE_FULL;
        temp_d  = TEMP_HOME;
        for (int i = 0; i < 4; i++) rt_d[i] = '0;
      end
      default: ;
    endcase
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      st_q        <= PS_STANDBY;
      gs_q        <= GS_STANDBY;
      pair_q      <= 1'b0;
      spool_q     <= '0;
      shift_q     <= '0;
      fuel_q      <= FUEL_FULL;
      chg_q       <= CHARGE_FULL;
      temp_q      <= TEMP_HOME;
      for (int i = 0; i < 4; i++) rt_q[i] <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        st_q    <= st_d;
        gs_q    <= gs_d;
        pair_q  <= pair_d;
        spool_q <= spool_d;
        shift_q <= shift_d;
        fuel_q  <= fuel_d;
        chg_q   <= chg_d;
        temp_q  <= temp_d;
        for (int i = 0; i < 4; i++) rt_q[i] <= rt_d[i];
      end
    end
  end

  // report encoding
  always_comb begin
    case (st_q)
      PS_A_START: pair_state_o = PAIR_CODE_A_START;
      PS_A_RUN:   pair_state_o = PAIR_CODE_A_RUN;
      PS_B_START: pair_state_o = PAIR_CODE_B_START;
      PS_B_RUN:   pair_state_o = PAIR_CODE_B_RUN;
      default:    pair_state_o = PAIR_CODE_STANDBY;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign gen_state_o      = gs_q;
  assign active_pair_o    = pair_q;
  assign fuel_ul_o        = fuel_q;
  assign battery_charge_o = chg_q;
  assign room_temp_o      = temp_q;
  assign run_time_gen1_o  = rt_q[0];
  assign run_time_gen2_o  = rt_q[1];
  assign run_time_gen3_o  = rt_q[2];
  assign run_time_gen4_o  = rt_q[3];

endmodule

/* verif/gprt_plant_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port of the generator rotation core,
// keeps its own copy of the plant state and compares every result beat.
module gprt_plant_checker #(
  parameter int unsigned RUN_TIME_BITS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gprt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gprt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [15:0]                      dt_ms_i,
  input  logic                             grid_ok_i,
  input  logic                             fire_alarm_i,
  input  logic                             cooling_enabled_i,
  input  logic                             auto_start_i,
  input  logic [19:0]                      ups_load_w_i,
  input  logic [19:0]                      server_load_w_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic [2:0]                       pair_state_o,
  input  logic [1:0]                       gen_state_o,
  input  logic                             active_pair_o,
  input  logic [29:0]                      fuel_ul_o,
  input  logic [36:0]                      battery_charge_o,
  input  logic [35:0]                      room_temp_o,
  input  logic [RUN_TIME_BITS-1:0]         run_time_gen1_o,
  input  logic [RUN_TIME_BITS-1:0]         run_time_gen2_o,
  input  logic [RUN_TIME_BITS-1:0]         run_time_gen3_o,
  input  logic [RUN_TIME_BITS-1:0]         run_time_gen4_o,
  output int                               mismatch_count_o,
  output int                               pending_o
);

  import gprt_pkg::*;

  localparam logic [63:0] RUN_MAX = (64'd1 << RUN_TIME_BITS) - 64'd1;

  typedef struct packed {
    logic [2:0]                        pair_code;
    logic [1:0]                        gen_code;
    logic                              pair_sel;
    logic [29:0]                       fuel_ul;
    logic [36:0]                       charge;
    logic [35:0]                       temp;
    logic [3:0][RUN_TIME_BITS-1:0]     run_ms;
  } plant_status_t;

  // plant state as the core should hold it
  logic [2:0]                     pair_code;
  gen_st_e                        gen_mode;
  logic                           pair_sel;
  logic [16:0]                    spool_ms;
  logic [26:0]                    shift_ms;
  logic [29:0]                    fuel;
  logic [36:0]                    charge;
  logic [35:0]                    temp;
  logic [3:0][RUN_TIME_BITS-1:0]  run_ms;

  // register copies
  logic [26:0] shift_len_cfg;
  logic [15:0] startup_cfg;

  plant_status_t expected_status_q [$];

  task automatic clear_plant();
    pair_code  = PAIR_CODE_STANDBY;
    gen_mode   = GS_STANDBY;
    pair_sel   = 1'b0;
    spool_ms   = '0;
    shift_ms   = '0;
    fuel       = FUEL_FULL;
    charge     = CHARGE_FULL;
    temp       = TEMP_HOME;
    run_ms     = '0;
  endtask

  task automatic park_generators();
    pair_code  = PAIR_CODE_STANDBY;
    gen_mode   = GS_STANDBY;
    spool_ms   = '0;
    shift_ms   = '0;
  endtask

  task automatic add_run_ms(input int slot, input logic [15:0] dt);
    logic [63:0] sum;
    sum = 64'(run_ms[slot]) + 64'(dt);
    run_ms[slot] = (sum > RUN_MAX) ? RUN_MAX[RUN_TIME_BITS-1:0] : sum[RUN_TIME_BITS-1:0];
  endtask

  task automatic add_shift_ms(input logic [15:0] dt);
    logic [27:0] sum;
    sum = {1'b0, shift_ms} + 28'(dt);
    shift_ms = sum[27] ? 27'h7FFFFFF : sum[26:0];
  endtask

  task automatic burn_fuel(input logic [63:0] amount);
    fuel = (amount >= 64'(fuel)) ? 30'd0 : fuel - amount[29:0];
  endtask

  // One input beat applied to the plant copy
  task automatic advance_plant(input op_e op, input logic [15:0] dt, input logic grid,
                               input logic fire, input logic cool, input logic autos,
                               input logic [19:0] ups, input logic [19:0] srv);
    logic [63:0] dt64;
    logic [63:0] sum;
    logic [63:0] cut;
    logic        online;
    dt64 = 64'(dt);
    case (op)
      OP_TICK: begin
        if (!grid && autos && fuel != 0 && !fire) begin
          case (pair_code)
            PAIR_CODE_STANDBY: begin
              pair_code  = PAIR_CODE_A_START;
              pair_sel   = 1'b0;
              gen_mode   = GS_STARTING;
              spool_ms   = '0;
              shift_ms   = '0;
            end
            PAIR_CODE_A_START: begin
              spool_ms = spool_ms + 17'(dt);
              if (spool_ms >= 17'(startup_cfg)) begin
                pair_code  = PAIR_CODE_A_RUN;
                gen_mode   = GS_RUNNING;
                spool_ms   = '0;
              end
            end
            PAIR_CODE_A_RUN: begin
              add_shift_ms(dt);
              add_run_ms(0, dt);
              add_run_ms(2, dt);
              burn_fuel(dt64 * 64'(FUEL_RUN_RATE));
              if (shift_ms >= shift_len_cfg && fuel != 0) begin
                pair_code = PAIR_CODE_B_START;
                pair_sel  = 1'b1;
                spool_ms  = '0;
              end
            end
            PAIR_CODE_B_START: begin
              // pair A keeps carrying the load while B spools up
              spool_ms = spool_ms + 17'(dt);
              add_run_ms(0, dt);
              add_run_ms(2, dt);
              burn_fuel(dt64 * 64'(FUEL_START_RATE));
              if (spool_ms >= 17'(startup_cfg)) begin
                pair_code  = PAIR_CODE_B_RUN;
                gen_mode   = GS_RUNNING;
                spool_ms   = '0;
                shift_ms   = '0;
              end
            end
            default: begin
              add_shift_ms(dt);
              add_run_ms(1, dt);
              add_run_ms(3, dt);
              burn_fuel(dt64 * 64'(FUEL_RUN_RATE));
              if (shift_ms >= shift_len_cfg && fuel != 0) begin
                pair_code  = PAIR_CODE_A_START;
                pair_sel   = 1'b0;
                spool_ms   = '0;
                gen_mode   = GS_STARTING;
              end
            end
          endcase
          if (fuel == 0) park_generators();
        end else if (grid || fire) begin
          if (pair_code != PAIR_CODE_STANDBY) park_generators();
        end

        online = grid || (gen_mode == GS_RUNNING);

        // battery: charge when powered, else discharge into the UPS load
        if (!online) begin
          cut = (dt64 * (64'(BATT_BASE_W) + 64'(ups))) >> 1;
          charge = (cut >= 64'(charge)) ? 37'd0 : charge - cut[36:0];
        end else if (charge < CHARGE_FULL) begin
          sum = 64'(charge) + dt64 * 64'(CHARGE_RATE);
          charge = (sum > 64'(CHARGE_FULL)) ? CHARGE_FULL : sum[36:0];
        end

        // room: cool toward home temperature or heat from the servers
        if (!(cool && online && !fire)) begin
          sum = 64'(temp) + dt64 * (64'(HEAT_BASE_W) + 64'(srv));
          temp = (sum > 64'(TEMP_MAX)) ? TEMP_MAX : sum[35:0];
        end else if (temp > TEMP_HOME) begin
          cut = dt64 * 64'(COOL_RATE);
          temp = (64'(temp - TEMP_HOME) <= cut) ? TEMP_HOME : temp - cut[35:0];
        end
      end
      OP_REFILL: begin
        fuel   = FUEL_FULL;
        charge = CHARGE_FULL;
        temp   = TEMP_HOME;
      end
      OP_RESET: clear_plant();
      default: ;
    endcase
  endtask

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plant_status_t hit;
    plant_status_t snap;
    int            bad;
    if (!rst_ni) begin
      clear_plant();
      shift_len_cfg = SHIFT_LEN_RST;
      startup_cfg   = STARTUP_RST;
      expected_status_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // register writes; spare indexes are ignored by the core
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SHIFT_LEN) shift_len_cfg = cfg_data_i;
        else if (cfg_idx_i == CFG_STARTUP) startup_cfg = cfg_data_i[15:0];
      end

      // result beat against the oldest expectation
      if (out_valid_o && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatch_count_o++;
        end else begin
          hit = expected_status_q.pop_front();
          bad = 0;
          bad += field_differs("pair_state", hit.pair_code, pair_state_o);
          bad += field_differs("gen_state", hit.gen_code, gen_state_o);
          bad += field_differs("active_pair", hit.pair_sel, active_pair_o);
          bad += field_differs("fuel_ul", hit.fuel_ul, fuel_ul_o);
          bad += field_differs("battery_charge", hit.charge, battery_charge_o);
          bad += field_differs("room_temp", hit.temp, room_temp_o);
          bad += field_differs("run_time_gen1", hit.run_ms[0], run_time_gen1_o);
          bad += field_differs("run_time_gen2", hit.run_ms[1], run_time_gen2_o);
          bad += field_differs("run_time_gen3", hit.run_ms[2], run_time_gen3_o);
          bad += field_differs("run_time_gen4", hit.run_ms[3], run_time_gen4_o);
          mismatch_count_o += bad;
        end
      end

      // input beat: step the plant and store the state after it
      if (in_valid_i && in_ready_o) begin
        advance_plant(op_e'(op_i), dt_ms_i, grid_ok_i, fire_alarm_i, cooling_enabled_i,
                      auto_start_i, ups_load_w_i, server_load_w_i);
        snap.pair_code = pair_code;
        snap.gen_code  = gen_mode;
        snap.pair_sel  = pair_sel;
        snap.fuel_ul   = fuel;
        snap.charge    = charge;
        snap.temp      = temp;
        snap.run_ms    = run_ms;
        expected_status_q.insert(expected_status_q.size(), snap);
      end

      pending_o = expected_status_q.size();
    end
  end

endmodule

/* verif/tb_generator_pair_rotation_tick_core.sv */
`timescale 1ns / 1ps

module tb_generator_pair_rotation_tick_core;

  import gprt_pkg::*;

  localparam int unsigned RUN_TIME_BITS = 40;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  CFG_IDX_SPARE_B = 2'd3;
  localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES    = {CFG_DATA_W{1'b1}};
  localparam logic [15:0] DT_MAX        = 16'hFFFF;
  localparam logic [19:0] LOAD_MAX      = 20'hFFFFF;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 4;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              op_i = OP_TICK;
  logic [15:0]             dt_ms_i = '0;
  logic                    grid_ok_i = 1'b0;
  logic                    fire_alarm_i = 1'b0;
  logic                    cooling_enabled_i = 1'b0;
  logic                    auto_start_i = 1'b0;
  logic [19:0]             ups_load_w_i = '0;
  logic [19:0]             server_load_w_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [2:0]              pair_state_o;
  logic [1:0]              gen_state_o;
  logic                    active_pair_o;
  logic [29:0]             fuel_ul_o;
  logic [36:0]             battery_charge_o;
  logic [35:0]             room_temp_o;
  logic [RUN_TIME_BITS-1:0] run_time_gen1_o;
  logic [RUN_TIME_BITS-1:0] run_time_gen2_o;
  logic [RUN_TIME_BITS-1:0] run_time_gen3_o;
  logic [RUN_TIME_BITS-1:0] run_time_gen4_o;

  int mismatch_count;
  int pending;
  int stall_cycles = 0;
  bit idle_on = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  generator_pair_rotation_tick_core #(.RUN_TIME_BITS(RUN_TIME_BITS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .op_i(op_i), .dt_ms_i(dt_ms_i),
    .grid_ok_i(grid_ok_i), .fire_alarm_i(fire_alarm_i),
    .cooling_enabled_i(cooling_enabled_i), .auto_start_i(auto_start_i),
    .ups_load_w_i(ups_load_w_i), .server_load_w_i(server_load_w_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pair_state_o(pair_state_o), .gen_state_o(gen_state_o),
    .active_pair_o(active_pair_o), .fuel_ul_o(fuel_ul_o),
    .battery_charge_o(battery_charge_o), .room_temp_o(room_temp_o),
    .run_time_gen1_o(run_time_gen1_o), .run_time_gen2_o(run_time_gen2_o),
    .run_time_gen3_o(run_time_gen3_o), .run_time_gen4_o(run_time_gen4_o)
  );

  gprt_plant_checker #(.RUN_TIME_BITS(RUN_TIME_BITS)) u_plant_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .op_i(op_i), .dt_ms_i(dt_ms_i),
    .grid_ok_i(grid_ok_i), .fire_alarm_i(fire_alarm_i),
    .cooling_enabled_i(cooling_enabled_i), .auto_start_i(auto_start_i),
    .ups_load_w_i(ups_load_w_i), .server_load_w_i(server_load_w_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pair_state_o(pair_state_o), .gen_state_o(gen_state_o),
    .active_pair_o(active_pair_o), .fuel_ul_o(fuel_ul_o),
    .battery_charge_o(battery_charge_o), .room_temp_o(room_temp_o),
    .run_time_gen1_o(run_time_gen1_o), .run_time_gen2_o(run_time_gen2_o),
    .run_time_gen3_o(run_time_gen3_o), .run_time_gen4_o(run_time_gen4_o),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: ready with random stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Drive one tick beat; called and returns at a falling edge
  task automatic send_beat(input op_e op, input logic [15:0] dt, input logic grid,
                           input logic fire, input logic cool, input logic autos,
                           input logic [19:0] ups, input logic [19:0] srv);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= op;
    dt_ms_i           <= dt;
    grid_ok_i         <= grid;
    fire_alarm_i      <= fire;
    cooling_enabled_i <= cool;
    auto_start_i      <= autos;
    ups_load_w_i      <= ups;
    server_load_w_i   <= srv;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stop sending and let every result drain before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Mostly sustained outages with random content, plus upkeep ops and noise
  task automatic run_random(input int beats, input int dt_cap, input int max_pct,
                            input int upkeep_pct, input int outage_pct, input bit quiet);
    op_e         op;
    logic [15:0] dt;
    logic        grid;
    logic        fire;
    logic        autos;
    logic [19:0] ups;
    logic [19:0] srv;
    int          pick;
    for (int n = 0; n < beats; n++) begin
      if (n % 50 == 0) idle_on = !quiet && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < upkeep_pct) op = OP_REFILL;
      else if (pick < upkeep_pct + upkeep_pct / 2) op = OP_RESET;
      else if (pick < upkeep_pct + upkeep_pct / 2 + 1) op = OP_NONE;
      else op = OP_TICK;

      pick = $urandom_range(0, 99);
      if (pick < max_pct) dt = DT_MAX;
      else if (pick < max_pct + 10) dt = '0;
      else if (pick < max_pct + 30) dt = 16'($urandom);
      else dt = 16'($urandom_range(0, dt_cap));

      if ($urandom_range(0, 99) < outage_pct) begin
        grid  = 1'b0;
        fire  = 1'b0;
        autos = 1'b1;
      end else begin
        grid  = 1'($urandom_range(0, 1));
        fire  = 1'($urandom_range(0, 1));
        autos = 1'($urandom_range(0, 1));
      end
      ups = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 5000));
      srv = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 5000));
      send_beat(op, dt, grid, fire, 1'($urandom_range(0, 1)), autos, ups, srv);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] shift_cfg;
    logic [CFG_DATA_W-1:0] startup_cfg;
    int beats;
    int dt_cap;
    int max_pct;
    int upkeep_pct;
    int outage_pct;
    bit quiet;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_on = 1'b1;

    // directed, reset register values
    send_beat(OP_NONE, DT_MAX, 1'b1, 1'b1, 1'b1, 1'b1, LOAD_MAX, LOAD_MAX);
    send_beat(OP_TICK, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 20'd0, 20'd0);
    // standby to A starting
    send_beat(OP_TICK, DT_MAX, 1'b0, 1'b0, 1'b1, 1'b1, LOAD_MAX, LOAD_MAX);
    // just short of spool-up
    send_beat(OP_TICK, 16'd3499, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // spool-up reached
    send_beat(OP_TICK, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // no auto start: hold
    send_beat(OP_TICK, DT_MAX, 1'b0, 1'b0, 1'b1, 1'b0, LOAD_MAX, 20'd0);
    // fire alarm forces standby
    send_beat(OP_TICK, DT_MAX, 1'b0, 1'b1, 1'b1, 1'b1, 20'd0, LOAD_MAX);
    send_beat(OP_REFILL, DT_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 20'd0, 20'd0);
    send_beat(OP_TICK, DT_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 20'd0, 20'd0);
    send_beat(OP_RESET, DT_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 20'd0, 20'd0);

    // directed rotation with a 1000 ms shift and no spool-up
    settle();
    write_reg(CFG_SHIFT_LEN, 27'd1000);
    write_reg(CFG_STARTUP, 27'd0);
    cfg_we_i <= 1'b0;
    send_beat(OP_TICK, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    send_beat(OP_TICK, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // shift done, B starting
    send_beat(OP_TICK, 16'd1000, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // B running
    send_beat(OP_TICK, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // back to A starting
    send_beat(OP_TICK, DT_MAX, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    send_beat(OP_TICK, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // stale shift timer: rotate
    send_beat(OP_TICK, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 20'd0, 20'd0);
    // grid back, pair kept
    send_beat(OP_TICK, DT_MAX, 1'b1, 1'b0, 1'b1, 1'b1, LOAD_MAX, LOAD_MAX);

    // random phases over several register settings
    for (int p = 0; p < 4; p++) begin
      quiet = 1'b0;
      case (p)
        0: begin
          shift_cfg = 27'd1000;  startup_cfg = 27'd0;
          beats = 170; dt_cap = 2000; max_pct = 5; upkeep_pct = 4; outage_pct = 85;
        end
        1: begin
          shift_cfg = 27'd200000;  startup_cfg = CFG_ALL_ONES;
          beats = 170; dt_cap = 65535; max_pct = 15; upkeep_pct = 4; outage_pct = 85;
        end
        2: begin
          // long shift, no refills: run the tank dry
          shift_cfg = CFG_ALL_ONES;  startup_cfg = 27'd60000;
          beats = 600; dt_cap = 65535; max_pct = 90; upkeep_pct = 0; outage_pct = 97;
        end
        default: begin
          shift_cfg   = 27'($urandom_range(1000, 2000000));
          startup_cfg = 27'($urandom_range(0, 60000));
          beats = 170; dt_cap = 20000; max_pct = 5; upkeep_pct = 4; outage_pct = 85;
          quiet = 1'b1;
        end
      endcase
      settle();
      if (p == 1) begin
        write_reg(CFG_IDX_SPARE_A, CFG_ALL_ONES);
        write_reg(CFG_IDX_SPARE_B, 27'd0);
      end
      write_reg(CFG_SHIFT_LEN, shift_cfg);
      write_reg(CFG_STARTUP, startup_cfg);
      cfg_we_i <= 1'b0;
      run_random(beats, dt_cap, max_pct, upkeep_pct, outage_pct, quiet);
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/gprt_pkg.sv
hdl/generator_pair_rotation_tick_core.sv
verif/gprt_plant_checker.sv
verif/tb_generator_pair_rotation_tick_core.sv
